/* hdl/block_range_add_range_sum_core_defines.svh */
// ----------------------------------------------------------------------------
// block range add / range sum core: assertion macros
// shared concurrent assertion forms used by the rtl files
// ----------------------------------------------------------------------------
`ifndef BLOCK_RANGE_ADD_RANGE_SUM_CORE_DEFINES_SVH
`define BLOCK_RANGE_ADD_RANGE_SUM_CORE_DEFINES_SVH

// same-cycle implication
`define RASD_ASSERT_IMPLY(name, clk_s, rstn_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("rasd assertion failed");

// next-cycle implication
`define RASD_ASSERT_NEXT(name, clk_s, rstn_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("rasd assertion failed");

`endif

/* hdl/rasd_pkg.sv */
// ----------------------------------------------------------------------------
// rasd_pkg
// shared types and constants of the block range add / range sum core
// ----------------------------------------------------------------------------
`default_nettype none

package rasd_pkg;

    localparam int CAPACITY_DEF   = 4096;
    localparam int BLOCK_SIZE_DEF = 64;
    localparam int NUM_BLOCKS_DEF = 64;

    localparam int COUNT_W   = 13;
    localparam int INDEX_W   = 12;
    localparam int OPERAND_W = 32;
    localparam int DATA_W    = 64;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd4096;

    localparam logic [1:0] REQ_SET   = 2'd0;
    localparam logic [1:0] REQ_ADD   = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;

    typedef struct packed {
        logic [1:0]                  req_type;
        logic [INDEX_W-1:0]          left_index;
        logic [INDEX_W-1:0]          right_index;
        logic signed [OPERAND_W-1:0] operand_value;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] range_sum;
        logic                     range_error;
    } result_t;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_ACC
    } alu_op_t;

    typedef struct packed {
        logic              en;
        alu_op_t           op;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
    } alu_req_t;

endpackage

`default_nettype wire

/* hdl/rasd_ram.sv */
// ----------------------------------------------------------------------------
// rasd_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module rasd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* hdl/rasd_alu.sv */
// ----------------------------------------------------------------------------
// rasd_alu
// shared 64-bit add / subtract / short multiply / accumulate unit with registered result
// ----------------------------------------------------------------------------
`default_nettype none

module rasd_alu #(
    parameter int MUL_W = 7
) (
    input  wire logic                      clk,
    input  wire rasd_pkg::alu_req_t        req,
    output logic [rasd_pkg::DATA_W-1:0]    y
);

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            case (req.op)
                rasd_pkg::ALU_ADD: y <= req.a + req.b;
                rasd_pkg::ALU_SUB: y <= req.a - req.b;
                // multiplier is only as wide as a block element count
                rasd_pkg::ALU_MUL: y <= rasd_pkg::DATA_W'(req.a * req.b[MUL_W-1:0]);
                rasd_pkg::ALU_ACC: y <= y + req.b;
                default:           y <= y;
            endcase
        end
    end

endmodule

`default_nettype wire

/* hdl/block_range_add_range_sum_core.sv */
// ----------------------------------------------------------------------------
// block_range_add_range_sum_core
// range add / range sum store over an array split into fixed-size blocks
// ----------------------------------------------------------------------------
// After reset the core sweeps all stores to zero, one entry per cycle, with
// busy high. A request is taken when start is high and busy is low; busy
// stays high until it is done. A request first steps block by block up to
// the block of left_index, then handles each block of the range in turn: a
// fully covered block updates only its pending add (add) or reads its pending
// add and block sum (query), while a partial block walks its elements, each
// passing through the one shared adder. A set runs the block search, then
// updates one element and its block sum; ignored requests never leave idle.
// A query result shows up for exactly one cycle on result with result_valid
// high and must be captured then; the core cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

`include "block_range_add_range_sum_core_defines.svh"

module block_range_add_range_sum_core #(
    parameter int CAPACITY   = rasd_pkg::CAPACITY_DEF,
    parameter int BLOCK_SIZE = rasd_pkg::BLOCK_SIZE_DEF,
    parameter int NUM_BLOCKS = rasd_pkg::NUM_BLOCKS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wr_en,
    input  wire logic [rasd_pkg::COUNT_W-1:0]   cfg_wr_data,
    input  wire logic                           start,
    input  wire rasd_pkg::req_t                 req,
    output logic                                busy,
    output logic                                result_valid,
    output rasd_pkg::result_t                   result
);

    localparam int DW     = rasd_pkg::DATA_W;
    localparam int AW     = $clog2(CAPACITY);
    localparam int BW     = $clog2(NUM_BLOCKS);
    localparam int CW     = $clog2(BLOCK_SIZE + 1);
    localparam int XRAW   = $clog2(NUM_BLOCKS * BLOCK_SIZE + 1);
    localparam int XW     = (XRAW > rasd_pkg::COUNT_W) ? XRAW : rasd_pkg::COUNT_W;
    localparam int LIMIT  = (CAPACITY < NUM_BLOCKS * BLOCK_SIZE) ?
                            CAPACITY : NUM_BLOCKS * BLOCK_SIZE;
    localparam int DEPTH  = (CAPACITY > NUM_BLOCKS) ? CAPACITY : NUM_BLOCKS;
    localparam int CLW    = $clog2(DEPTH);

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_FIND, ST_SEG,
        ST_SET_RD, ST_SET_NV, ST_SET_DIFF, ST_SET_SUM, ST_SET_WR,
        ST_WA_RD, ST_WA_ADD, ST_WA_WR,
        ST_WQ_RD, ST_WQ_MUL, ST_WQ_ACC,
        ST_P_RD, ST_P_MUL, ST_EW,
        ST_B_MUL, ST_B_ADD, ST_B_WR,
        ST_TOT, ST_NEXT
    } state_t;

    state_t                          state_reg;
    logic [rasd_pkg::COUNT_W-1:0]    count_reg;
    logic [CLW-1:0]                  clr_reg;
    logic [1:0]                      kind_reg;
    logic [XW-1:0]                   l_reg;
    logic [XW-1:0]                   r_reg;
    logic [DW-1:0]                   v_reg;
    logic [DW-1:0]                   acc_reg;
    logic [BW-1:0]                   b_reg;
    logic [XW-1:0]                   base_reg;
    logic [XW-1:0]                   hi_reg;
    logic [XW-1:0]                   i_reg;
    logic [CW-1:0]                   cnt_reg;
    logic                            ew_done_reg;
    logic                            v1_reg;
    logic                            v2_reg;
    logic [XW-1:0]                   a1_reg;
    logic [XW-1:0]                   a2_reg;
    logic                            result_valid_reg;
    rasd_pkg::result_t               result_reg;

    logic [rasd_pkg::COUNT_W-1:0]    eff_count;
    logic [XW-1:0]                   in_l;
    logic [XW-1:0]                   in_r;
    logic                            in_bad;
    logic                            in_l_ok;
    logic                            accept;
    logic [XW-1:0]                   seg_end;
    logic [XW-1:0]                   seg_lo;
    logic [XW-1:0]                   seg_hi;
    logic                            seg_full;
    logic                            ew_issue;
    logic                            is_query;

    logic                            elem_we;
    logic [AW-1:0]                   elem_waddr;
    logic [DW-1:0]                   elem_wdata;
    logic                            elem_re;
    logic [AW-1:0]                   elem_raddr;
    logic [DW-1:0]                   elem_rdata;
    logic                            bsum_we;
    logic [BW-1:0]                   bsum_waddr;
    logic [DW-1:0]                   bsum_wdata;
    logic                            bsum_re;
    logic [DW-1:0]                   bsum_rdata;
    logic                            pend_we;
    logic [DW-1:0]                   pend_wdata;
    logic                            pend_re;
    logic [DW-1:0]                   pend_rdata;
    rasd_pkg::alu_req_t              alu_req;
    logic [DW-1:0]                   alu_y;

    assign eff_count = (32'(count_reg) > LIMIT) ? rasd_pkg::COUNT_W'(LIMIT) : count_reg;
    assign in_l      = XW'(req.left_index);
    assign in_r      = XW'(req.right_index);
    assign in_l_ok   = in_l < XW'(eff_count);
    assign in_bad    = (in_l > in_r) || (in_r >= XW'(eff_count));
    assign accept    = start && !busy;
    assign is_query  = (kind_reg == rasd_pkg::REQ_QUERY);

    assign seg_end  = base_reg + XW'(BLOCK_SIZE - 1);
    assign seg_lo   = (l_reg > base_reg) ? l_reg : base_reg;
    assign seg_hi   = (r_reg < seg_end) ? r_reg : seg_end;
    assign seg_full = (seg_lo == base_reg) && (seg_hi == seg_end);
    assign ew_issue = (state_reg == ST_EW) && !ew_done_reg;

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // store ports and shared unit steering
    always_comb
    begin
        elem_we    = 1'b0;
        elem_waddr = AW'(a2_reg);
        elem_wdata = alu_y;
        elem_re    = 1'b0;
        elem_raddr = AW'(i_reg);
        bsum_we    = 1'b0;
        bsum_waddr = b_reg;
        bsum_wdata = alu_y;
        bsum_re    = 1'b0;
        pend_we    = 1'b0;
        pend_wdata = alu_y;
        pend_re    = 1'b0;
        alu_req    = '0;
        alu_req.op = rasd_pkg::ALU_ADD;

        unique case (state_reg)
            ST_CLEAR:
            begin
                elem_we    = 32'(clr_reg) < CAPACITY;
                elem_waddr = AW'(clr_reg);
                elem_wdata = '0;
                bsum_we    = 32'(clr_reg) < NUM_BLOCKS;
                bsum_waddr = BW'(clr_reg);
                bsum_wdata = '0;
                pend_we    = 32'(clr_reg) < NUM_BLOCKS;
                pend_wdata = '0;
            end
            ST_SET_RD:
            begin
                elem_re    = 1'b1;
                elem_raddr = AW'(l_reg);
                bsum_re    = 1'b1;
                pend_re    = 1'b1;
            end
            ST_SET_NV:
            begin
                alu_req = '{en: 1'b1, op: rasd_pkg::ALU_SUB, a: v_reg, b: pend_rdata};
            end
            ST_SET_DIFF:
            begin
                elem_we    = 1'b1;
                elem_waddr = AW'(l_reg);
                alu_req    = '{en: 1'b1, op: rasd_pkg::ALU_SUB, a: alu_y, b: elem_rdata};
            end
            ST_SET_SUM:
            begin
                alu_req = '{en: 1'b1, op: rasd_pkg::ALU_ADD, a: alu_y, b: bsum_rdata};
            end
            ST_SET_WR:
            begin
                bsum_we = 1'b1;
            end
            ST_WA_RD:
            begin
                pend_re = 1'b1;
            end
            ST_WA_ADD:
            begin
                alu_req = '{en: 1'b1, op: rasd_pkg::ALU_ADD, a: pend_rdata, b: v_reg};
            end
            ST_WA_WR:
            begin
                pend_we = 1'b1;
            end
            ST_WQ_RD:
            begin
                pend_re = 1'b1;
                bsum_re = 1'b1;
            end
            ST_WQ_MUL:
            begin
                alu_req = '{en: 1'b1, op: rasd_pkg::ALU_MUL, a: pend_rdata,
                            b: DW'(BLOCK_SIZE)};
            end
            ST_WQ_ACC:
            begin
                alu_req = '{en: 1'b1, op: rasd_pkg::ALU_ACC, a: '0, b: bsum_rdata};
            end
            ST_P_RD:
            begin
                pend_re = 1'b1;
            end
            ST_P_MUL:
            begin
                alu_req = '{en: 1'b1, op: rasd_pkg::ALU_MUL, a: pend_rdata, b: DW'(cnt_reg)};
            end
            ST_EW:
            begin
                elem_re = ew_issue;
                elem_we = v2_reg;
                if (v1_reg)
                begin
                    if (is_query)
                    begin
                        alu_req = '{en: 1'b1, op: rasd_pkg::ALU_ACC, a: '0, b: elem_rdata};
                    end
                    else
                    begin
                        alu_req = '{en: 1'b1, op: rasd_pkg::ALU_ADD, a: elem_rdata, b: v_reg};
                    end
                end
            end
            ST_B_MUL:
            begin
                bsum_re = 1'b1;
                alu_req = '{en: 1'b1, op: rasd_pkg::ALU_MUL, a: v_reg, b: DW'(cnt_reg)};
            end
            ST_B_ADD:
            begin
                alu_req = '{en: 1'b1, op: rasd_pkg::ALU_ADD, a: alu_y, b: bsum_rdata};
            end
            ST_B_WR:
            begin
                bsum_we = 1'b1;
            end
            ST_TOT:
            begin
                alu_req = '{en: 1'b1, op: rasd_pkg::ALU_ADD, a: acc_reg, b: alu_y};
            end
            default:
            begin
                alu_req.en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            count_reg        <= rasd_pkg::COUNT_RESET;
            clr_reg          <= '0;
            ew_done_reg      <= 1'b0;
            v1_reg           <= 1'b0;
            v2_reg           <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= 1'b0;
            if (cfg_wr_en)
            begin
                count_reg <= cfg_wr_data;
            end

            // element walk pipeline: read, then add (or accumulate for a query), then write back (adds only)
            v1_reg <= ew_issue;
            a1_reg <= i_reg;
            v2_reg <= v1_reg && !is_query;
            a2_reg <= a1_reg;

            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (32'(clr_reg) == DEPTH - 1)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        kind_reg <= req.req_type;
                        l_reg    <= in_l;
                        r_reg    <= in_r;
                        v_reg    <= DW'(req.operand_value);
                        acc_reg  <= '0;
                        b_reg    <= '0;
                        base_reg <= '0;
                        case (req.req_type)
                            rasd_pkg::REQ_SET:
                            begin
                                if (in_l_ok)
                                begin
                                    state_reg <= ST_FIND;
                                end
                            end
                            rasd_pkg::REQ_ADD:
                            begin
                                if (!in_bad)
                                begin
                                    state_reg <= ST_FIND;
                                end
                            end
                            rasd_pkg::REQ_QUERY:
                            begin
                                if (in_bad)
                                begin
                                    result_valid_reg       <= 1'b1;
                                    result_reg.range_sum   <= '0;
                                    result_reg.range_error <= 1'b1;
                                end
                                else
                                begin
                                    state_reg <= ST_FIND;
                                end
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_FIND:
                begin
                    if (l_reg >= base_reg + XW'(BLOCK_SIZE))
                    begin
                        b_reg    <= b_reg + 1'b1;
                        base_reg <= base_reg + XW'(BLOCK_SIZE);
                    end
                    else if (kind_reg == rasd_pkg::REQ_SET)
                    begin
                        state_reg <= ST_SET_RD;
                    end
                    else
                    begin
                        state_reg <= ST_SEG;
                    end
                end
                ST_SEG:
                begin
                    hi_reg      <= seg_hi;
                    i_reg       <= seg_lo;
                    cnt_reg     <= CW'(seg_hi - seg_lo + XW'(1));
                    ew_done_reg <= 1'b0;
                    if (seg_full)
                    begin
                        state_reg <= is_query ? ST_WQ_RD : ST_WA_RD;
                    end
                    else
                    begin
                        state_reg <= is_query ? ST_P_RD : ST_EW;
                    end
                end
                ST_SET_RD:   state_reg <= ST_SET_NV;
                ST_SET_NV:   state_reg <= ST_SET_DIFF;
                ST_SET_DIFF: state_reg <= ST_SET_SUM;
                ST_SET_SUM:  state_reg <= ST_SET_WR;
                ST_SET_WR:   state_reg <= ST_IDLE;
                ST_WA_RD:    state_reg <= ST_WA_ADD;
                ST_WA_ADD:   state_reg <= ST_WA_WR;
                ST_WA_WR:    state_reg <= ST_NEXT;
                ST_WQ_RD:    state_reg <= ST_WQ_MUL;
                ST_WQ_MUL:   state_reg <= ST_WQ_ACC;
                ST_WQ_ACC:   state_reg <= ST_TOT;
                ST_P_RD:     state_reg <= ST_P_MUL;
                ST_P_MUL:    state_reg <= ST_EW;
                ST_EW:
                begin
                    if (ew_issue)
                    begin
                        if (i_reg == hi_reg)
                        begin
                            ew_done_reg <= 1'b1;
                        end
                        else
                        begin
                            i_reg <= i_reg + 1'b1;
                        end
                    end
                    if (ew_done_reg && !v1_reg && !v2_reg)
                    begin
                        state_reg <= is_query ? ST_TOT : ST_B_MUL;
                    end
                end
                ST_B_MUL:    state_reg <= ST_B_ADD;
                ST_B_ADD:    state_reg <= ST_B_WR;
                ST_B_WR:     state_reg <= ST_NEXT;
                ST_TOT:      state_reg <= ST_NEXT;
                ST_NEXT:
                begin
                    if (is_query)
                    begin
                        acc_reg <= alu_y;
                    end
                    if (hi_reg == r_reg)
                    begin
                        state_reg <= ST_IDLE;
                        if (is_query)
                        begin
                            result_valid_reg       <= 1'b1;
                            result_reg.range_sum   <= alu_y;
                            result_reg.range_error <= 1'b0;
                        end
                    end
                    else
                    begin
                        b_reg     <= b_reg + 1'b1;
                        base_reg  <= base_reg + XW'(BLOCK_SIZE);
                        state_reg <= ST_SEG;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    rasd_ram #(.WIDTH(DW), .DEPTH(CAPACITY)) u_elem_ram (
        .clk   (clk),
        .we    (elem_we),
        .waddr (elem_waddr),
        .wdata (elem_wdata),
        .re    (elem_re),
        .raddr (elem_raddr),
        .rdata (elem_rdata)
    );

    rasd_ram #(.WIDTH(DW), .DEPTH(NUM_BLOCKS)) u_bsum_ram (
        .clk   (clk),
        .we    (bsum_we),
        .waddr (bsum_waddr),
        .wdata (bsum_wdata),
        .re    (bsum_re),
        .raddr (b_reg),
        .rdata (bsum_rdata)
    );

    rasd_ram #(.WIDTH(DW), .DEPTH(NUM_BLOCKS)) u_pend_ram (
        .clk   (clk),
        .we    (pend_we),
        .waddr (bsum_waddr),
        .wdata (pend_wdata),
        .re    (pend_re),
        .raddr (b_reg),
        .rdata (pend_rdata)
    );

    rasd_alu #(.MUL_W(CW)) u_alu (
        .clk (clk),
        .req (alu_req),
        .y   (alu_y)
    );

    `RASD_ASSERT_IMPLY(a_err_zero, clk, rst_n, result_valid && result.range_error, result.range_sum == '0)
    `RASD_ASSERT_IMPLY(a_no_wr_idle, clk, rst_n, state_reg == ST_IDLE, !elem_we && !bsum_we && !pend_we)
    `RASD_ASSERT_IMPLY(a_cnt_range, clk, rst_n, state_reg == ST_P_MUL || state_reg == ST_B_MUL, cnt_reg != '0 && 32'(cnt_reg) <= BLOCK_SIZE)
    `RASD_ASSERT_NEXT(a_wb_add_only, clk, rst_n, v1_reg && kind_reg != rasd_pkg::REQ_ADD, !v2_reg)

endmodule

`default_nettype wire
